// ----- sv/rdm_pkg.sv -----
package rdm_pkg;

  localparam int FRAME_WIDTH  = 640;
  localparam int FRAME_HEIGHT = 480;

  localparam int DEPTH_W    = 16;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 9;
  localparam int COORD_W    = 12;
  localparam int SIZE_W     = 11;
  localparam int SPAN_W     = 13;
  localparam int SUM_W      = 35;
  localparam int COUNT_W    = 19;
  localparam int MEAN_W     = 24;
  localparam int FRAC_W     = 8;
  localparam int NUM_W      = SUM_W + FRAC_W;
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int REG_IDX_W  = 3;
  localparam int REG_DATA_W = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic signed [COORD_W-1:0] RST_ROI_LEFT      = '0;
  localparam logic signed [COORD_W-1:0] RST_ROI_TOP       = '0;
  localparam logic [SIZE_W-1:0]         RST_ROI_WIDTH     = SIZE_W'(640);
  localparam logic [SIZE_W-1:0]         RST_ROI_HEIGHT    = SIZE_W'(480);
  localparam logic [DEPTH_W-1:0]        RST_DEPTH_FLOOR   = DEPTH_W'(300);
  localparam logic [DEPTH_W-1:0]        RST_DEPTH_CEILING = DEPTH_W'(10000);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROI_LEFT,
    REG_ROI_TOP,
    REG_ROI_WIDTH,
    REG_ROI_HEIGHT,
    REG_DEPTH_FLOOR,
    REG_DEPTH_CEILING
  } reg_index_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } frame_total_t;

  typedef struct packed {
    logic         push;
    frame_total_t total;
  } frame_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_HOLD
  } div_state_t;

endpackage

// ----- sv/rdm_if.sv -----
interface rdm_pixel_if;
  logic                        valid;
  logic                        ready;
  logic [rdm_pkg::DEPTH_W-1:0] depth_mm;
  logic [rdm_pkg::COL_W-1:0]   column;
  logic [rdm_pkg::ROW_W-1:0]   row;
  logic                        frame_end;

  modport source(output valid, depth_mm, column, row, frame_end, input ready);
  modport sink(input valid, depth_mm, column, row, frame_end, output ready);
endinterface

interface rdm_result_if;
  logic                        valid;
  logic                        ready;
  logic [rdm_pkg::MEAN_W-1:0]  mean_depth_q8;
  logic [rdm_pkg::COUNT_W-1:0] valid_count;

  modport source(output valid, mean_depth_q8, valid_count, input ready);
  modport sink(input valid, mean_depth_q8, valid_count, output ready);
endinterface

// ----- sv/rdm_front.sv -----
module rdm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [rdm_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [rdm_pkg::REG_DATA_W-1:0] wr_data,
  rdm_pixel_if.sink                      pix,
  input  rdm_pkg::queue_status_t         q_status,
  output rdm_pkg::frame_push_t           q_push
);

  logic signed [rdm_pkg::COORD_W-1:0] roi_left;
  logic signed [rdm_pkg::COORD_W-1:0] roi_top;
  logic [rdm_pkg::SIZE_W-1:0]         roi_width;
  logic [rdm_pkg::SIZE_W-1:0]         roi_height;
  logic [rdm_pkg::DEPTH_W-1:0]        depth_floor;
  logic [rdm_pkg::DEPTH_W-1:0]        depth_ceiling;

  logic [rdm_pkg::SUM_W-1:0]   depth_sum;
  logic [rdm_pkg::COUNT_W-1:0] pixel_count;
  logic [rdm_pkg::SUM_W-1:0]   depth_sum_next;
  logic [rdm_pkg::COUNT_W-1:0] pixel_count_next;

  logic signed [rdm_pkg::SPAN_W-1:0] col_pos;
  logic signed [rdm_pkg::SPAN_W-1:0] row_pos;
  logic signed [rdm_pkg::SPAN_W-1:0] col_start;
  logic signed [rdm_pkg::SPAN_W-1:0] row_start;
  logic signed [rdm_pkg::SPAN_W-1:0] col_stop;
  logic signed [rdm_pkg::SPAN_W-1:0] row_stop;
  logic col_in;
  logic row_in;
  logic depth_ok;
  logic hit;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      roi_left      <= rdm_pkg::RST_ROI_LEFT;
      roi_top       <= rdm_pkg::RST_ROI_TOP;
      roi_width     <= rdm_pkg::RST_ROI_WIDTH;
      roi_height    <= rdm_pkg::RST_ROI_HEIGHT;
      depth_floor   <= rdm_pkg::RST_DEPTH_FLOOR;
      depth_ceiling <= rdm_pkg::RST_DEPTH_CEILING;
    end else if (wr_en) begin
      case (rdm_pkg::reg_index_t'(wr_index))
        rdm_pkg::REG_ROI_LEFT:      roi_left      <= wr_data[rdm_pkg::COORD_W-1:0];
        rdm_pkg::REG_ROI_TOP:       roi_top       <= wr_data[rdm_pkg::COORD_W-1:0];
        rdm_pkg::REG_ROI_WIDTH:     roi_width     <= wr_data[rdm_pkg::SIZE_W-1:0];
        rdm_pkg::REG_ROI_HEIGHT:    roi_height    <= wr_data[rdm_pkg::SIZE_W-1:0];
        rdm_pkg::REG_DEPTH_FLOOR:   depth_floor   <= wr_data[rdm_pkg::DEPTH_W-1:0];
        rdm_pkg::REG_DEPTH_CEILING: depth_ceiling <= wr_data[rdm_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix.ready = !q_status.full;
  assign accept    = pix.valid && pix.ready;

  always_comb begin
    col_pos   = $signed(rdm_pkg::SPAN_W'(pix.column));
    row_pos   = $signed(rdm_pkg::SPAN_W'(pix.row));
    col_start = rdm_pkg::SPAN_W'(roi_left);
    row_start = rdm_pkg::SPAN_W'(roi_top);
    col_stop  = col_start + $signed(rdm_pkg::SPAN_W'(roi_width));
    row_stop  = row_start + $signed(rdm_pkg::SPAN_W'(roi_height));
    col_in    = (col_pos >= col_start) && (col_pos < col_stop) &&
                (rdm_pkg::SIZE_W'(pix.column) < rdm_pkg::SIZE_W'(rdm_pkg::FRAME_WIDTH));
    row_in    = (row_pos >= row_start) && (row_pos < row_stop) &&
                (rdm_pkg::SIZE_W'(pix.row) < rdm_pkg::SIZE_W'(rdm_pkg::FRAME_HEIGHT));
    depth_ok  = (pix.depth_mm > depth_floor) && (pix.depth_mm < depth_ceiling);
    hit       = col_in && row_in && depth_ok && (pixel_count != rdm_pkg::COUNT_MAX);
    depth_sum_next   = depth_sum + (hit ? rdm_pkg::SUM_W'(pix.depth_mm) : '0);
    pixel_count_next = pixel_count + rdm_pkg::COUNT_W'(hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_sum   <= '0;
      pixel_count <= '0;
    end else if (accept) begin
      if (pix.frame_end) begin
        depth_sum   <= '0;
        pixel_count <= '0;
      end else begin
        depth_sum   <= depth_sum_next;
        pixel_count <= pixel_count_next;
      end
    end
  end

  assign q_push.push        = accept && pix.frame_end;
  assign q_push.total.sum   = depth_sum_next;
  assign q_push.total.count = pixel_count_next;

endmodule

// ----- sv/rdm_queue.sv -----
module rdm_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  rdm_pkg::frame_push_t   q_push,
  input  logic                   pop,
  output rdm_pkg::queue_status_t q_status,
  output rdm_pkg::frame_total_t  head
);

  rdm_pkg::frame_total_t entries [rdm_pkg::QUEUE_DEPTH];

  logic [rdm_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rdm_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rdm_pkg::QCOUNT_W-1:0] fill;
  logic                         do_push;
  logic                         do_pop;

  assign q_status.full  = (fill == rdm_pkg::QCOUNT_W'(rdm_pkg::QUEUE_DEPTH));
  assign q_status.empty = (fill == '0);
  assign do_push        = q_push.push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= q_push.total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == rdm_pkg::QPTR_W'(rdm_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == rdm_pkg::QPTR_W'(rdm_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + rdm_pkg::QCOUNT_W'(do_push) - rdm_pkg::QCOUNT_W'(do_pop);
    end
  end

endmodule

// ----- sv/rdm_div.sv -----
module rdm_div (
  input  logic                   clk,
  input  logic                   rst,
  input  rdm_pkg::queue_status_t q_status,
  input  rdm_pkg::frame_total_t  head,
  output logic                   pop,
  rdm_result_if.source           res
);

  rdm_pkg::div_state_t state;
  rdm_pkg::div_state_t state_next;

  logic [rdm_pkg::NUM_W-1:0]   num;
  logic [rdm_pkg::COUNT_W-1:0] rem;
  logic [rdm_pkg::COUNT_W-1:0] divisor;
  logic [rdm_pkg::STEP_W-1:0]  step;
  logic [rdm_pkg::COUNT_W:0]   rem_sh;
  logic [rdm_pkg::COUNT_W:0]   rem_diff;
  logic                        q_bit;
  logic                        load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdm_pkg::DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    case (state)
      rdm_pkg::DIV_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = rdm_pkg::DIV_RUN;
        end
      end
      rdm_pkg::DIV_RUN: begin
        if (step == rdm_pkg::STEP_W'(rdm_pkg::NUM_W - 1)) begin
          state_next = rdm_pkg::DIV_HOLD;
        end
      end
      rdm_pkg::DIV_HOLD: begin
        if (!res.valid || res.ready) begin
          load_out   = 1'b1;
          state_next = rdm_pkg::DIV_IDLE;
        end
      end
      default: state_next = rdm_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    rem_sh   = {rem, num[rdm_pkg::NUM_W-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    q_bit    = (rem_sh >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      num     <= {head.sum, rdm_pkg::FRAC_W'(0)};
      divisor <= head.count;
      rem     <= '0;
      step    <= '0;
    end else if (state == rdm_pkg::DIV_RUN) begin
      num  <= {num[rdm_pkg::NUM_W-2:0], q_bit};
      rem  <= q_bit ? rem_diff[rdm_pkg::COUNT_W-1:0] : rem_sh[rdm_pkg::COUNT_W-1:0];
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load_out) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res.mean_depth_q8 <= (divisor == '0) ? '0 : num[rdm_pkg::MEAN_W-1:0];
      res.valid_count   <= divisor;
    end
  end

endmodule

// ----- sv/roi_depth_mean_core.sv -----
// Pixels are accepted one per cycle; ready drops only while the two-entry frame queue is full.
// A frame's result follows its last accepted word through these steps: the total is dequeued,
// run through the bit-serial divider and loaded into the output register, which can wait on ready.
// The divider handles one frame total at a time and takes the next only after its result is loaded.
// Reset restores the register defaults and clears the accumulators, the queue and the output.
module roi_depth_mean_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [rdm_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [rdm_pkg::REG_DATA_W-1:0] wr_data,
  rdm_pixel_if.sink                      pix,
  rdm_result_if.source                   res
);

  rdm_pkg::frame_push_t   q_push;
  rdm_pkg::queue_status_t q_status;
  rdm_pkg::frame_total_t  head;
  logic                   pop;

  rdm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .pix      (pix),
    .q_status (q_status),
    .q_push   (q_push)
  );

  rdm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_push   (q_push),
    .pop      (pop),
    .q_status (q_status),
    .head     (head)
  );

  rdm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .res      (res)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push.push && q_status.full))
    else $error("frame total pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_status.empty))
    else $error("divider took a frame total from an empty queue");

  a_empty_mean_zero: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.valid_count == '0) |-> (res.mean_depth_q8 == '0))
    else $error("nonzero mean reported for an empty region");

  a_mean_in_range: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.mean_depth_q8[rdm_pkg::MEAN_W-1:rdm_pkg::FRAC_W] != '1))
    else $error("mean depth exceeds the largest passing depth");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !res.valid)
    else $error("result word presented right after reset");

endmodule
